// ----- design/esc_pkg.sv -----
package esc_pkg;

  localparam int FLOOR_COUNT = 4;
  localparam int FLOOR_W = 3;
  localparam int FLOOR_IDX_W = $clog2(FLOOR_COUNT);
  localparam int TIMER_W = 16;
  localparam logic [TIMER_W-1:0] DOOR_TICKS_RESET = 16'd300;
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_UP    = 3'd1,
    MODE_DOWN  = 3'd2,
    MODE_DOORS = 3'd3,
    MODE_EMERG = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    DRV_REST = 2'd0,
    DRV_LOW  = 2'd1,
    DRV_HIGH = 2'd2
  } drive_t;

  // one datapath operation per cycle, issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_PRE,
    OP_CABIN,
    OP_REMOTE,
    OP_MODE,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t                 op;
    logic [FLOOR_IDX_W-1:0] cabin_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic local_trip;
    logic remote_trip;
  } dp_status_t;

endpackage

// ----- design/elevator_scan_controller_core.sv -----
// Elevator scan controller for a four-floor car, stepped once per tick word.
//
// Input channel (in_valid / in_stall): one tick word carries the floor sensor,
// new cabin presses, a dispatcher target and both emergency inputs. A word is
// taken when in_valid is high and in_stall is low.
// Output channel (out_valid / out_stall): exactly one status word per tick
// word: floor, target, mode, motor command, emergency latch, queued floors.
// Config channel (cfg_valid / cfg_ready): writes door_open_ticks; always
// ready, and meant to be written only while no tick is in flight.
//
// The controller walks each tick word in steps: sensor and local emergency,
// one cabin button per cycle, remote target, mode handler, hand-off. A local
// emergency goes straight from the sensor step to hand-off, a remote one
// from the remote step. A new tick word can be taken in the cycle after
// hand-off, and never before the last one has been handed off.
// A stalled output word stays in the output register while the next tick is
// taken and worked; hand-off of that tick waits until the word is taken.
// Reset (rst, synchronous): idle at floor one, no target, empty queue,
// timer zero, latch clear, motor at rest, door_open_ticks = 300.
module elevator_scan_controller_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [esc_pkg::FLOOR_W-1:0]     sensor_floor,
  input  logic [esc_pkg::FLOOR_COUNT-1:0] cabin_mask,
  input  logic [esc_pkg::FLOOR_W-1:0]     remote_target,
  input  logic                            remote_emergency,
  input  logic                            local_emergency,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [esc_pkg::FLOOR_W-1:0]     floor_now,
  output logic [esc_pkg::FLOOR_W-1:0]     target_now,
  output logic [2:0]                      mode_code,
  output logic [1:0]                      motor_drive,
  output logic                            emergency_latched,
  output logic [esc_pkg::FLOOR_COUNT-1:0] queued_mask,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [esc_pkg::TIMER_W-1:0]     door_open_ticks
);
  import esc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // config register takes a word in any cycle
  assign cfg_ready = 1'b1;

  // sequence the tick steps and own both handshakes
  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // hold mode, floor, queue, timer and latch; advance them per command
  esc_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_ticks         (door_open_ticks),
    .sensor_floor      (sensor_floor),
    .cabin_mask        (cabin_mask),
    .remote_target     (remote_target),
    .remote_emergency  (remote_emergency),
    .local_emergency   (local_emergency),
    .floor_now         (floor_now),
    .target_now        (target_now),
    .mode_code         (mode_code),
    .motor_drive       (motor_drive),
    .emergency_latched (emergency_latched),
    .queued_mask       (queued_mask)
  );

endmodule

// ----- design/esc_ctrl.sv -----
module esc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  esc_pkg::dp_status_t status,
  output esc_pkg::dp_cmd_t    cmd
);
  import esc_pkg::*;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_PRE,
    ST_CABIN,
    ST_REMOTE,
    ST_MODE,
    ST_EMIT
  } state_t;

  state_t                 state;
  logic [FLOOR_IDX_W-1:0] cabin_idx;
  logic                   emit_go;

  assign emit_go = (state == ST_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    cmd.cabin_idx = cabin_idx;
    unique case (state)
      ST_WAIT:   cmd.op = in_valid ? OP_LOAD : OP_NONE;
      ST_PRE:    cmd.op = OP_PRE;
      ST_CABIN:  cmd.op = OP_CABIN;
      ST_REMOTE: cmd.op = OP_REMOTE;
      ST_MODE:   cmd.op = OP_MODE;
      ST_EMIT:   cmd.op = emit_go ? OP_EMIT : OP_NONE;
      default:   cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_WAIT;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
      cabin_idx <= '0;
    end else begin
      if (out_valid && !out_stall && !emit_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_WAIT: begin
          if (in_valid) begin
            state    <= ST_PRE;
            in_stall <= 1'b1;
          end
        end
        ST_PRE: begin
          cabin_idx <= '0;
          state     <= status.local_trip ? ST_EMIT : ST_CABIN;
        end
        ST_CABIN: begin
          cabin_idx <= cabin_idx + FLOOR_IDX_W'(1);
          if (cabin_idx == FLOOR_IDX_W'(FLOOR_COUNT - 1)) begin
            state <= ST_REMOTE;
          end
        end
        ST_REMOTE: begin
          state <= status.remote_trip ? ST_EMIT : ST_MODE;
        end
        ST_MODE: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_valid <= 1'b1;
            in_stall  <= 1'b0;
            state     <= ST_WAIT;
          end
        end
        default: begin
          state <= ST_WAIT;
        end
      endcase
    end
  end

endmodule

// ----- design/esc_datapath.sv -----
module esc_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  esc_pkg::dp_cmd_t                   cmd,
  output esc_pkg::dp_status_t                status,
  input  logic                               cfg_we,
  input  logic [esc_pkg::TIMER_W-1:0]        cfg_ticks,
  input  logic [esc_pkg::FLOOR_W-1:0]        sensor_floor,
  input  logic [esc_pkg::FLOOR_COUNT-1:0]    cabin_mask,
  input  logic [esc_pkg::FLOOR_W-1:0]        remote_target,
  input  logic                               remote_emergency,
  input  logic                               local_emergency,
  output logic [esc_pkg::FLOOR_W-1:0]        floor_now,
  output logic [esc_pkg::FLOOR_W-1:0]        target_now,
  output logic [2:0]                         mode_code,
  output logic [1:0]                         motor_drive,
  output logic                               emergency_latched,
  output logic [esc_pkg::FLOOR_COUNT-1:0]    queued_mask
);
  import esc_pkg::*;

  typedef struct packed {
    mode_t  mode;
    drive_t motor;
    logic   doors;
  } move_t;

  // latched input word
  logic [FLOOR_W-1:0]     sensor_q;
  logic [FLOOR_COUNT-1:0] cabin_q;
  logic [FLOOR_W-1:0]     remote_q;
  logic                   remote_em_q;
  logic                   local_em_q;

  // controller state
  mode_t                  mode;
  logic [FLOOR_W-1:0]     floor_reg;
  logic [FLOOR_W-1:0]     target_reg;
  logic [FLOOR_COUNT-1:0] queued;
  logic [TIMER_W-1:0]     door_timer;
  logic                   emergency_flag;
  drive_t                 motor_reg;
  logic [TIMER_W-1:0]     door_ticks;

  mode_t                  mode_next;
  logic [FLOOR_W-1:0]     floor_next;
  logic [FLOOR_W-1:0]     target_next;
  logic [FLOOR_COUNT-1:0] queued_next;
  logic [TIMER_W-1:0]     timer_next;
  logic                   flag_next;
  drive_t                 motor_next;

  logic [FLOOR_W-1:0]     req_floor;
  logic                   req_en;
  logic                   assign_ok;
  logic [FLOOR_W-1:0]     scan_floor;
  logic [FLOOR_W-1:0]     away;
  logic [TIMER_W-1:0]     timer_inc;
  move_t                  move_req;
  move_t                  move_scan;

  function automatic logic floor_valid(input logic [FLOOR_W-1:0] f);
    return (f >= FLOOR_W'(1)) && (f <= FLOOR_W'(FLOOR_COUNT));
  endfunction

  function automatic logic [FLOOR_COUNT-1:0] floor_bit(input logic [FLOOR_W-1:0] f);
    return FLOOR_COUNT'(1) << (f - FLOOR_W'(1));
  endfunction

  function automatic move_t head_for(input logic [FLOOR_W-1:0] t,
                                     input logic [FLOOR_W-1:0] cur_f);
    move_t m;
    if (t > cur_f) begin
      m = '{mode: MODE_UP, motor: DRV_HIGH, doors: 1'b0};
    end else if (t < cur_f) begin
      m = '{mode: MODE_DOWN, motor: DRV_HIGH, doors: 1'b0};
    end else begin
      m = '{mode: MODE_DOORS, motor: DRV_REST, doors: 1'b1};
    end
    return m;
  endfunction

  // directional scan over the queued floors
  function automatic logic [FLOOR_W-1:0] next_floor(input logic [FLOOR_COUNT-1:0] q,
                                                    input logic [FLOOR_W-1:0] cur_f,
                                                    input mode_t m,
                                                    input logic [FLOOR_W-1:0] tgt);
    logic [FLOOR_W-1:0] above;
    logic [FLOOR_W-1:0] below;
    logic [FLOOR_W-1:0] best;
    logic [FLOOR_W-1:0] fl;
    logic               go_up;
    above = '0;
    below = '0;
    for (int i = FLOOR_COUNT - 1; i >= 0; i--) begin
      fl = FLOOR_W'(i + 1);
      if (q[i] && fl > cur_f) above = fl;
    end
    for (int i = 0; i < FLOOR_COUNT; i++) begin
      fl = FLOOR_W'(i + 1);
      if (q[i] && fl < cur_f) below = fl;
    end
    go_up = (m == MODE_UP) || (m == MODE_IDLE && tgt != '0 && tgt > cur_f);
    if (go_up) begin
      best = (above != '0) ? above : below;
    end else begin
      best = (below != '0) ? below : above;
    end
    // nothing above or below: only the current floor can be queued
    if ((m == MODE_IDLE || m == MODE_DOORS) && best == '0 && q != '0) begin
      best = cur_f;
    end
    return best;
  endfunction

  assign status.local_trip  = local_em_q && !emergency_flag;
  assign status.remote_trip = remote_em_q && !emergency_flag;

  assign req_floor = (cmd.op == OP_CABIN) ? FLOOR_W'(cmd.cabin_idx) + FLOOR_W'(1) : remote_q;
  assign req_en    = (cmd.op == OP_CABIN) ? cabin_q[cmd.cabin_idx]
                   : (floor_valid(remote_q) && remote_q != floor_reg);
  assign assign_ok = req_en && !emergency_flag && floor_valid(req_floor)
                   && !(req_floor == floor_reg && mode == MODE_IDLE)
                   && ((queued & floor_bit(req_floor)) == '0);

  assign scan_floor = next_floor(queued, floor_reg, mode, target_reg);
  assign move_req   = head_for(req_floor, floor_reg);
  assign move_scan  = head_for(scan_floor, floor_reg);
  assign away       = (mode == MODE_UP) ? target_reg - floor_reg : floor_reg - target_reg;
  assign timer_inc  = (door_timer == TIMER_MAX) ? door_timer : door_timer + TIMER_W'(1);

  always_comb begin
    mode_next   = mode;
    floor_next  = floor_reg;
    target_next = target_reg;
    queued_next = queued;
    timer_next  = door_timer;
    flag_next   = emergency_flag;
    motor_next  = motor_reg;
    unique case (cmd.op)
      OP_PRE: begin
        if (status.local_trip) begin
          mode_next   = MODE_EMERG;
          flag_next   = 1'b1;
          target_next = '0;
          queued_next = '0;
          motor_next  = DRV_REST;
        end else if (floor_valid(sensor_q)) begin
          floor_next = sensor_q;
        end
      end
      OP_CABIN, OP_REMOTE: begin
        if (assign_ok) begin
          queued_next = queued | floor_bit(req_floor);
          if (mode == MODE_IDLE) begin
            target_next = req_floor;
            mode_next   = move_req.mode;
            motor_next  = move_req.motor;
            if (move_req.doors) begin
              timer_next  = '0;
              queued_next = queued_next & ~floor_bit(floor_reg);
            end
          end
        end
        if (cmd.op == OP_REMOTE && status.remote_trip) begin
          mode_next   = MODE_EMERG;
          flag_next   = 1'b1;
          target_next = '0;
          queued_next = '0;
          motor_next  = DRV_REST;
        end
      end
      OP_MODE: begin
        unique case (mode)
          MODE_IDLE: begin
            if (queued != '0) begin
              target_next = scan_floor;
              if (scan_floor != '0) begin
                mode_next  = move_scan.mode;
                motor_next = move_scan.motor;
                if (move_scan.doors) begin
                  timer_next  = '0;
                  queued_next = queued & ~floor_bit(floor_reg);
                end
              end
            end
          end
          MODE_UP, MODE_DOWN: begin
            // slow down one floor before the target
            if (target_reg != '0 && away <= FLOOR_W'(1)) begin
              motor_next = DRV_LOW;
            end
            if (floor_reg == target_reg) begin
              mode_next   = MODE_DOORS;
              timer_next  = '0;
              motor_next  = DRV_REST;
              queued_next = queued & ~floor_bit(floor_reg);
            end
          end
          MODE_DOORS: begin
            timer_next = timer_inc;
            if (timer_inc >= door_ticks) begin
              if (queued != '0) begin
                target_next = scan_floor;
                if (scan_floor != '0) begin
                  mode_next  = move_scan.mode;
                  motor_next = move_scan.motor;
                  if (move_scan.doors) begin
                    timer_next  = '0;
                    queued_next = queued & ~floor_bit(floor_reg);
                  end
                end
              end else begin
                mode_next   = MODE_IDLE;
                target_next = '0;
                motor_next  = DRV_REST;
              end
            end
          end
          MODE_EMERG: begin
          end
          default: begin
            mode_next   = MODE_IDLE;
            target_next = '0;
            motor_next  = DRV_REST;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      floor_reg      <= FLOOR_W'(1);
      target_reg     <= '0;
      queued         <= '0;
      door_timer     <= '0;
      emergency_flag <= 1'b0;
      motor_reg      <= DRV_REST;
      door_ticks     <= DOOR_TICKS_RESET;
    end else begin
      mode           <= mode_next;
      floor_reg      <= floor_next;
      target_reg     <= target_next;
      queued         <= queued_next;
      door_timer     <= timer_next;
      emergency_flag <= flag_next;
      motor_reg      <= motor_next;
      if (cfg_we) begin
        door_ticks <= cfg_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      sensor_q    <= sensor_floor;
      cabin_q     <= cabin_mask;
      remote_q    <= remote_target;
      remote_em_q <= remote_emergency;
      local_em_q  <= local_emergency;
    end
    if (cmd.op == OP_EMIT) begin
      floor_now         <= floor_reg;
      target_now        <= target_reg;
      mode_code         <= mode;
      motor_drive       <= motor_reg;
      emergency_latched <= emergency_flag;
      queued_mask       <= queued;
    end
  end

endmodule
